### hw/rtl/ogtr_pkg.sv
// ----------------------------------------------------------------------------
// ogtr_pkg: shared types and constants for the Greeks Taylor repricing core
// Word formats, base table word codes, result records and saturation helper.
// ----------------------------------------------------------------------------
package ogtr_pkg;

    localparam int WORD_W      = 48;
    localparam int SUM_W       = WORD_W + 4;
    localparam int IDX_W       = 8;
    localparam int SEL_W       = 4;
    localparam int WORDS       = 11;
    localparam int OPTIONS_DEF = 256;
    localparam int FRAC_DEF    = 24;

    localparam logic MODE_LOAD    = 1'b0;
    localparam logic MODE_REPRICE = 1'b1;

    localparam logic [SEL_W-1:0] W_CALL   = 4'd0;
    localparam logic [SEL_W-1:0] W_PUT    = 4'd1;
    localparam logic [SEL_W-1:0] W_CDELTA = 4'd2;
    localparam logic [SEL_W-1:0] W_PDELTA = 4'd3;
    localparam logic [SEL_W-1:0] W_GAMMA  = 4'd4;
    localparam logic [SEL_W-1:0] W_VEGA   = 4'd5;
    localparam logic [SEL_W-1:0] W_THETA  = 4'd6;
    localparam logic [SEL_W-1:0] W_RHOC   = 4'd7;
    localparam logic [SEL_W-1:0] W_RHOP   = 4'd8;
    localparam logic [SEL_W-1:0] W_VANNA  = 4'd9;
    localparam logic [SEL_W-1:0] W_VOMMA  = 4'd10;

    typedef logic signed [WORD_W-1:0] t_word;

    localparam t_word WORD_MAX = {1'b0, {(WORD_W-1){1'b1}}};
    localparam t_word WORD_MIN = {1'b1, {(WORD_W-1){1'b0}}};

    typedef struct packed {
        t_word c_prc;
        t_word p_prc;
        t_word c_dlt;
        t_word p_dlt;
        t_word gamma;
        t_word vega;
        t_word theta;
        t_word rho_c;
        t_word rho_p;
        t_word vanna;
        t_word vomma;
    } t_row;

    // First-order products, all formed from the shifts directly.
    typedef struct packed {
        t_word cd_ds;
        t_word pd_ds;
        t_word g_ds;
        t_word a_dv;
        t_word a_ds;
        t_word m_dv;
        t_word v_dv;
    } t_lin;

    // Second-order products, formed from the squared and cross shifts.
    typedef struct packed {
        t_word g_ds2h;
        t_word m_dv2h;
        t_word a_cross;
    } t_sq;

    typedef struct packed {
        logic [IDX_W-1:0] entry_echo;
        t_word            new_call_price;
        t_word            new_put_price;
        t_word            new_call_delta;
        t_word            new_put_delta;
        t_word            new_vega;
        t_word            kept_gamma;
        t_word            kept_theta;
        t_word            kept_rho_call;
        t_word            kept_rho_put;
        t_word            kept_vanna;
        t_word            kept_vomma;
    } t_result;

    function automatic t_word sat_word(input logic signed [SUM_W-1:0] v);
        t_word r;
        if ((&v[SUM_W-1:WORD_W-1]) || !(|v[SUM_W-1:WORD_W-1])) begin
            r = v[WORD_W-1:0];
        end else if (v[SUM_W-1]) begin
            r = WORD_MIN;
        end else begin
            r = WORD_MAX;
        end
        return r;
    endfunction

endpackage

### hw/rtl/ogtr_if.sv
// ----------------------------------------------------------------------------
// ogtr_if: request and result channels of the repricing core
// Valid/ready channels carrying one item each; the source drives valid.
// ----------------------------------------------------------------------------
interface ogtr_req_if;
    logic                          valid;
    logic                          ready;
    logic                          mode;
    logic [ogtr_pkg::IDX_W-1:0]    option_index;
    logic [ogtr_pkg::SEL_W-1:0]    word_select;
    ogtr_pkg::t_word               load_value;
    ogtr_pkg::t_word               spot_shift;
    ogtr_pkg::t_word               vol_shift;

    modport source (output valid, mode, option_index, word_select, load_value,
                    spot_shift, vol_shift, input ready);
    modport sink   (input valid, mode, option_index, word_select, load_value,
                    spot_shift, vol_shift, output ready);
endinterface

interface ogtr_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [ogtr_pkg::IDX_W-1:0]    entry_echo;
    ogtr_pkg::t_word               new_call_price;
    ogtr_pkg::t_word               new_put_price;
    ogtr_pkg::t_word               new_call_delta;
    ogtr_pkg::t_word               new_put_delta;
    ogtr_pkg::t_word               new_vega;
    ogtr_pkg::t_word               kept_gamma;
    ogtr_pkg::t_word               kept_theta;
    ogtr_pkg::t_word               kept_rho_call;
    ogtr_pkg::t_word               kept_rho_put;
    ogtr_pkg::t_word               kept_vanna;
    ogtr_pkg::t_word               kept_vomma;

    modport source (output valid, entry_echo, new_call_price, new_put_price,
                    new_call_delta, new_put_delta, new_vega, kept_gamma,
                    kept_theta, kept_rho_call, kept_rho_put, kept_vanna,
                    kept_vomma, input ready);
    modport sink   (input valid, entry_echo, new_call_price, new_put_price,
                    new_call_delta, new_put_delta, new_vega, kept_gamma,
                    kept_theta, kept_rho_call, kept_rho_put, kept_vanna,
                    kept_vomma, output ready);
endinterface

### hw/rtl/ogtr_table.sv
// ----------------------------------------------------------------------------
// ogtr_table: base Greeks memory
// One row per option; a write updates one word, a read returns the whole row
// through an output register.
// ----------------------------------------------------------------------------
module ogtr_table #(
    parameter int OPTIONS = ogtr_pkg::OPTIONS_DEF,
    parameter int AW      = 8
) (
    input  logic                       i_clk,
    input  logic                       i_en,
    input  logic                       i_we,
    input  logic [AW-1:0]              i_addr,
    input  logic [ogtr_pkg::SEL_W-1:0] i_sel,
    input  ogtr_pkg::t_word            i_wdata,
    output ogtr_pkg::t_row             o_row
);

    ogtr_pkg::t_word r_mem [OPTIONS][ogtr_pkg::WORDS];
    ogtr_pkg::t_row  r_row;

    always_ff @(posedge i_clk) begin
        if (i_we && (i_sel < ogtr_pkg::SEL_W'(ogtr_pkg::WORDS))) begin
            r_mem[i_addr][i_sel] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_row.c_prc <= r_mem[i_addr][ogtr_pkg::W_CALL];
            r_row.p_prc <= r_mem[i_addr][ogtr_pkg::W_PUT];
            r_row.c_dlt <= r_mem[i_addr][ogtr_pkg::W_CDELTA];
            r_row.p_dlt <= r_mem[i_addr][ogtr_pkg::W_PDELTA];
            r_row.gamma <= r_mem[i_addr][ogtr_pkg::W_GAMMA];
            r_row.vega  <= r_mem[i_addr][ogtr_pkg::W_VEGA];
            r_row.theta <= r_mem[i_addr][ogtr_pkg::W_THETA];
            r_row.rho_c <= r_mem[i_addr][ogtr_pkg::W_RHOC];
            r_row.rho_p <= r_mem[i_addr][ogtr_pkg::W_RHOP];
            r_row.vanna <= r_mem[i_addr][ogtr_pkg::W_VANNA];
            r_row.vomma <= r_mem[i_addr][ogtr_pkg::W_VOMMA];
        end
    end

    assign o_row = r_row;

endmodule

### hw/rtl/ogtr_mul.sv
// ----------------------------------------------------------------------------
// ogtr_mul: pipelined fixed-point multiplier
// Four half-width partial products, a summing stage, then an arithmetic
// shift with saturation. Three register stages.
// ----------------------------------------------------------------------------
module ogtr_mul #(
    parameter int SHIFT = ogtr_pkg::FRAC_DEF
) (
    input  logic            i_clk,
    input  logic            i_en,
    input  ogtr_pkg::t_word i_a,
    input  ogtr_pkg::t_word i_b,
    output ogtr_pkg::t_word o_p
);

    localparam int W  = ogtr_pkg::WORD_W;
    localparam int H  = W / 2;
    localparam int PW = 2 * W;

    logic signed [2*H-1:0] r_hh;
    logic signed [2*H:0]   r_hl;
    logic signed [2*H:0]   r_lh;
    logic [2*H-1:0]        r_ll;
    logic signed [PW-1:0]  r_prod;
    logic signed [PW-1:0]  w_sh;
    ogtr_pkg::t_word       r_p;

    // The low halves are unsigned, so they get a zero above them.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_hh <= $signed(i_a[W-1:H]) * $signed(i_b[W-1:H]);
            r_hl <= $signed(i_a[W-1:H]) * $signed({1'b0, i_b[H-1:0]});
            r_lh <= $signed({1'b0, i_a[H-1:0]}) * $signed(i_b[W-1:H]);
            r_ll <= i_a[H-1:0] * i_b[H-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= (PW'(r_hh) << (2*H)) + (PW'(r_hl) << H) + (PW'(r_lh) << H)
                      + PW'(r_ll);
        end
    end

    assign w_sh = r_prod >>> SHIFT;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if ((&w_sh[PW-1:W-1]) || !(|w_sh[PW-1:W-1])) begin
                r_p <= w_sh[W-1:0];
            end else if (w_sh[PW-1]) begin
                r_p <= ogtr_pkg::WORD_MIN;
            end else begin
                r_p <= ogtr_pkg::WORD_MAX;
            end
        end
    end

    assign o_p = r_p;

endmodule

### hw/rtl/ogtr_combine.sv
// ----------------------------------------------------------------------------
// ogtr_combine: Taylor term summation
// Adds the product terms to the base words over three register stages and
// saturates each updated Greek to the word range.
// ----------------------------------------------------------------------------
module ogtr_combine (
    input  logic                       i_clk,
    input  logic                       i_en,
    input  logic [ogtr_pkg::IDX_W-1:0] i_echo,
    input  ogtr_pkg::t_row             i_row,
    input  ogtr_pkg::t_lin             i_lin,
    input  ogtr_pkg::t_sq              i_sq,
    output ogtr_pkg::t_result          o_res
);

    localparam int S = ogtr_pkg::SUM_W;
    localparam int W = ogtr_pkg::WORD_W;

    logic signed [W:0]          r_cl;
    logic signed [W:0]          r_pl;
    logic signed [W:0]          r_ca;
    logic signed [W:0]          r_cb;
    logic signed [W:0]          r_dsh;
    logic signed [W:0]          r_v1;
    ogtr_pkg::t_word            r_mdv;
    ogtr_pkg::t_row             r_row8;
    logic [ogtr_pkg::IDX_W-1:0] r_echo8;

    logic signed [W+1:0]        r_common;
    logic signed [W:0]          r_cl9;
    logic signed [W:0]          r_pl9;
    ogtr_pkg::t_word            r_cdelta;
    ogtr_pkg::t_word            r_pdelta;
    ogtr_pkg::t_word            r_vega;
    ogtr_pkg::t_row             r_row9;
    logic [ogtr_pkg::IDX_W-1:0] r_echo9;

    ogtr_pkg::t_result          r_res;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_cl    <= (W+1)'(i_row.c_prc) + (W+1)'(i_lin.cd_ds);
            r_pl    <= (W+1)'(i_row.p_prc) + (W+1)'(i_lin.pd_ds);
            r_ca    <= (W+1)'(i_sq.g_ds2h) + (W+1)'(i_lin.v_dv);
            r_cb    <= (W+1)'(i_sq.m_dv2h) + (W+1)'(i_sq.a_cross);
            r_dsh   <= (W+1)'(i_lin.g_ds) + (W+1)'(i_lin.a_dv);
            r_v1    <= (W+1)'(i_row.vega) + (W+1)'(i_lin.a_ds);
            r_mdv   <= i_lin.m_dv;
            r_row8  <= i_row;
            r_echo8 <= i_echo;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_common <= (W+2)'(r_ca) + (W+2)'(r_cb);
            r_cdelta <= ogtr_pkg::sat_word(S'(r_row8.c_dlt) + S'(r_dsh));
            r_pdelta <= ogtr_pkg::sat_word(S'(r_row8.p_dlt) + S'(r_dsh));
            r_vega   <= ogtr_pkg::sat_word(S'(r_v1) + S'(r_mdv));
            r_cl9    <= r_cl;
            r_pl9    <= r_pl;
            r_row9   <= r_row8;
            r_echo9  <= r_echo8;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_res.entry_echo     <= r_echo9;
            r_res.new_call_price <= ogtr_pkg::sat_word(S'(r_cl9) + S'(r_common));
            r_res.new_put_price  <= ogtr_pkg::sat_word(S'(r_pl9) + S'(r_common));
            r_res.new_call_delta <= r_cdelta;
            r_res.new_put_delta  <= r_pdelta;
            r_res.new_vega       <= r_vega;
            r_res.kept_gamma     <= r_row9.gamma;
            r_res.kept_theta     <= r_row9.theta;
            r_res.kept_rho_call  <= r_row9.rho_c;
            r_res.kept_rho_put   <= r_row9.rho_p;
            r_res.kept_vanna     <= r_row9.vanna;
            r_res.kept_vomma     <= r_row9.vomma;
        end
    end

    assign o_res = r_res;

endmodule

### hw/rtl/option_greeks_taylor_reprice_core.sv
// ----------------------------------------------------------------------------
// option_greeks_taylor_reprice_core: second-order Greeks repricing
//
//   Channel  Dir  Payload                                         Result
//   i_req    in   mode, option_index, word_select, load/shifts    load or reprice
//   o_rsp    out  entry_echo, updated prices/deltas/vega, Greeks  one per reprice
//
// One item is accepted per cycle unless the pipeline halts. A reprice result
// passes through the table read port register, the first bank of 48-bit
// multipliers, the second-order multipliers and the summation, then the
// output register. Loads write the table at acceptance, so a reprice in the
// very next cycle already sees the new word. Reset clears the stage valid bits
// only; table rows hold nothing defined until loaded. The pipeline halts only
// while a result waits in the output register and another one is ready to
// take its place.
// ----------------------------------------------------------------------------
module option_greeks_taylor_reprice_core #(
    parameter int OPTIONS   = ogtr_pkg::OPTIONS_DEF,
    parameter int FRAC_BITS = ogtr_pkg::FRAC_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    ogtr_req_if.sink    i_req,
    ogtr_rsp_if.source  o_rsp
);

    localparam int AW    = (OPTIONS > 1) ? $clog2(OPTIONS) : 1;
    localparam int LAST  = 10;
    localparam int NM1   = 10;
    localparam int NM2   = 3;
    localparam int IW    = ogtr_pkg::IDX_W;

    function automatic logic [AW-1:0] f_wrap(input logic [IW-1:0] idx);
        logic [AW-1:0] r;
        r = '0;
        for (int i = 0; i < (1 << IW); i++) begin
            if (idx == IW'(i)) begin
                r = AW'(i % OPTIONS);
            end
        end
        return r;
    endfunction

    logic                  w_adv;
    logic                  w_acc;
    logic [AW-1:0]         w_addr;
    ogtr_pkg::t_row        w_row1;

    logic                  r_vld [1:LAST];
    ogtr_pkg::t_word       r_ds1;
    ogtr_pkg::t_word       r_dv1;
    logic [IW-1:0]         r_echo [1:7];
    ogtr_pkg::t_row        r_row [2:7];
    ogtr_pkg::t_lin        w_lin4;
    ogtr_pkg::t_lin        r_lin [5:7];
    ogtr_pkg::t_sq         w_sq7;

    ogtr_pkg::t_word       w_m1a [NM1];
    ogtr_pkg::t_word       w_m1b [NM1];
    ogtr_pkg::t_word       w_m1p [NM1];
    ogtr_pkg::t_word       w_m2a [NM2];
    ogtr_pkg::t_word       w_m2b [NM2];
    ogtr_pkg::t_word       w_m2p [NM2];

    ogtr_pkg::t_result     w_res;
    ogtr_pkg::t_result     r_out;
    logic                  r_out_valid;

    // Everything moves unless a finished result is stuck and another follows.
    assign w_adv = !r_out_valid || o_rsp.ready || !r_vld[LAST];
    assign w_acc = i_req.valid && w_adv;
    assign i_req.ready = w_adv;
    assign w_addr = f_wrap(i_req.option_index);

    ogtr_table #(
        .OPTIONS (OPTIONS),
        .AW      (AW)
    ) u_table (
        .i_clk   (i_clk),
        .i_en    (w_adv),
        .i_we    (w_acc && (i_req.mode == ogtr_pkg::MODE_LOAD)),
        .i_addr  (w_addr),
        .i_sel   (i_req.word_select),
        .i_wdata (i_req.load_value),
        .o_row   (w_row1)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 1; k <= LAST; k++) begin
                r_vld[k] <= 1'b0;
            end
        end else if (w_adv) begin
            r_vld[1] <= w_acc && (i_req.mode == ogtr_pkg::MODE_REPRICE);
            for (int k = 2; k <= LAST; k++) begin
                r_vld[k] <= r_vld[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_ds1     <= i_req.spot_shift;
            r_dv1     <= i_req.vol_shift;
            r_echo[1] <= i_req.option_index;
            for (int k = 2; k <= 7; k++) begin
                r_echo[k] <= r_echo[k-1];
            end
            r_row[2] <= w_row1;
            for (int k = 3; k <= 7; k++) begin
                r_row[k] <= r_row[k-1];
            end
            r_lin[5] <= w_lin4;
            r_lin[6] <= r_lin[5];
            r_lin[7] <= r_lin[6];
        end
    end

    // First bank: products of base words with the raw shifts, the squares and the cross product.
    assign w_m1a[0] = w_row1.c_dlt;       assign w_m1b[0] = r_ds1;
    assign w_m1a[1] = w_row1.p_dlt;       assign w_m1b[1] = r_ds1;
    assign w_m1a[2] = w_row1.gamma;       assign w_m1b[2] = r_ds1;
    assign w_m1a[3] = w_row1.vanna;       assign w_m1b[3] = r_dv1;
    assign w_m1a[4] = w_row1.vanna;       assign w_m1b[4] = r_ds1;
    assign w_m1a[5] = w_row1.vomma;       assign w_m1b[5] = r_dv1;
    assign w_m1a[6] = w_row1.vega;        assign w_m1b[6] = r_dv1;
    assign w_m1a[7] = r_ds1;              assign w_m1b[7] = r_ds1;
    assign w_m1a[8] = r_dv1;              assign w_m1b[8] = r_dv1;
    assign w_m1a[9] = r_ds1;              assign w_m1b[9] = r_dv1;

    for (genvar g = 0; g < NM1; g++) begin : g_mul1
        ogtr_mul #(
            .SHIFT (FRAC_BITS)
        ) u_mul (
            .i_clk (i_clk),
            .i_en  (w_adv),
            .i_a   (w_m1a[g]),
            .i_b   (w_m1b[g]),
            .o_p   (w_m1p[g])
        );
    end

    assign w_lin4.cd_ds = w_m1p[0];
    assign w_lin4.pd_ds = w_m1p[1];
    assign w_lin4.g_ds  = w_m1p[2];
    assign w_lin4.a_dv  = w_m1p[3];
    assign w_lin4.a_ds  = w_m1p[4];
    assign w_lin4.m_dv  = w_m1p[5];
    assign w_lin4.v_dv  = w_m1p[6];

    // Second bank: the half terms take one extra bit of shift in one step.
    assign w_m2a[0] = r_row[4].gamma;  assign w_m2b[0] = w_m1p[7];
    assign w_m2a[1] = r_row[4].vomma;  assign w_m2b[1] = w_m1p[8];
    assign w_m2a[2] = r_row[4].vanna;  assign w_m2b[2] = w_m1p[9];

    for (genvar g = 0; g < NM2; g++) begin : g_mul2
        ogtr_mul #(
            .SHIFT ((g == 2) ? FRAC_BITS : FRAC_BITS + 1)
        ) u_mul (
            .i_clk (i_clk),
            .i_en  (w_adv),
            .i_a   (w_m2a[g]),
            .i_b   (w_m2b[g]),
            .o_p   (w_m2p[g])
        );
    end

    assign w_sq7.g_ds2h  = w_m2p[0];
    assign w_sq7.m_dv2h  = w_m2p[1];
    assign w_sq7.a_cross = w_m2p[2];

    ogtr_combine u_combine (
        .i_clk  (i_clk),
        .i_en   (w_adv),
        .i_echo (r_echo[7]),
        .i_row  (r_row[7]),
        .i_lin  (r_lin[7]),
        .i_sq   (w_sq7),
        .o_res  (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv && r_vld[LAST]) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv && r_vld[LAST]) begin
            r_out <= w_res;
        end
    end

    assign o_rsp.valid          = r_out_valid;
    assign o_rsp.entry_echo     = r_out.entry_echo;
    assign o_rsp.new_call_price = r_out.new_call_price;
    assign o_rsp.new_put_price  = r_out.new_put_price;
    assign o_rsp.new_call_delta = r_out.new_call_delta;
    assign o_rsp.new_put_delta  = r_out.new_put_delta;
    assign o_rsp.new_vega       = r_out.new_vega;
    assign o_rsp.kept_gamma     = r_out.kept_gamma;
    assign o_rsp.kept_theta     = r_out.kept_theta;
    assign o_rsp.kept_rho_call  = r_out.kept_rho_call;
    assign o_rsp.kept_rho_put   = r_out.kept_rho_put;
    assign o_rsp.kept_vanna     = r_out.kept_vanna;
    assign o_rsp.kept_vomma     = r_out.kept_vomma;

endmodule

### sim/testbench.sv
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the Greeks Taylor repricing core
// Loads base Greeks into the option table and reprices entries with directed
// and random spot and volatility shifts. A predictor keeps its own copy of the table and
// computes every result; a checker compares each whole result record with it.
// ----------------------------------------------------------------------------
module testbench;
    import ogtr_pkg::*;

    localparam int MAX_QUIET = 20000;
    localparam int LATENCY   = 11;

    typedef logic signed [95:0] t_wide;

    logic i_clk;
    logic i_rst_n;

    ogtr_req_if req_ch ();
    ogtr_rsp_if rsp_ch ();

    option_greeks_taylor_reprice_core dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (req_ch.sink),
        .o_rsp  (rsp_ch.source)
    );

    t_word       greek_table [256][WORDS];
    bit          loaded      [256][WORDS];
    t_result     pending_prices[$];
    int          send_idle_pct;
    int          recv_stall_pct;
    int          mismatches;
    int          results_seen;
    int          loads_sent;
    int          reprices_sent;
    int          quiet_cycles;

    always #10 i_clk = ~i_clk;

    // Fixed-point product: floor shift then saturation to the word range.
    function automatic t_word fx_mul(t_word a, t_word b, int sh);
        t_wide p;
        t_wide q;
        p = t_wide'(a) * t_wide'(b);
        q = p >>> sh;
        if (q > t_wide'(WORD_MAX)) return WORD_MAX;
        if (q < t_wide'(WORD_MIN)) return WORD_MIN;
        return q[WORD_W-1:0];
    endfunction

    function automatic t_word clamp(t_wide v);
        if (v > t_wide'(WORD_MAX)) return WORD_MAX;
        if (v < t_wide'(WORD_MIN)) return WORD_MIN;
        return v[WORD_W-1:0];
    endfunction

    function automatic t_result reprice(logic [7:0] idx, t_word ds, t_word dv);
        t_result r;
        t_word   e [WORDS];
        t_word   ds2, dv2, dsdv;
        t_wide   common, dshift;
        e = greek_table[idx];
        ds2   = fx_mul(ds, ds, FRAC_DEF);
        dv2   = fx_mul(dv, dv, FRAC_DEF);
        dsdv  = fx_mul(ds, dv, FRAC_DEF);
        common = t_wide'(fx_mul(e[W_GAMMA], ds2, FRAC_DEF + 1))
               + t_wide'(fx_mul(e[W_VEGA], dv, FRAC_DEF))
               + t_wide'(fx_mul(e[W_VOMMA], dv2, FRAC_DEF + 1))
               + t_wide'(fx_mul(e[W_VANNA], dsdv, FRAC_DEF));
        dshift = t_wide'(fx_mul(e[W_GAMMA], ds, FRAC_DEF))
               + t_wide'(fx_mul(e[W_VANNA], dv, FRAC_DEF));
        r.entry_echo     = idx;
        r.new_call_price = clamp(t_wide'(e[W_CALL])
                                 + t_wide'(fx_mul(e[W_CDELTA], ds, FRAC_DEF)) + common);
        r.new_put_price  = clamp(t_wide'(e[W_PUT])
                                 + t_wide'(fx_mul(e[W_PDELTA], ds, FRAC_DEF)) + common);
        r.new_call_delta = clamp(t_wide'(e[W_CDELTA]) + dshift);
        r.new_put_delta  = clamp(t_wide'(e[W_PDELTA]) + dshift);
        r.new_vega       = clamp(t_wide'(e[W_VEGA])
                                 + t_wide'(fx_mul(e[W_VANNA], ds, FRAC_DEF))
                                 + t_wide'(fx_mul(e[W_VOMMA], dv, FRAC_DEF)));
        r.kept_gamma     = e[W_GAMMA];
        r.kept_theta     = e[W_THETA];
        r.kept_rho_call  = e[W_RHOC];
        r.kept_rho_put   = e[W_RHOP];
        r.kept_vanna     = e[W_VANNA];
        r.kept_vomma     = e[W_VOMMA];
        return r;
    endfunction

    function automatic t_word rand_word();
        t_word w;
        case ($urandom_range(0, 5))
            0: w = WORD_MAX;
            1: w = WORD_MIN;
            2: w = t_word'({$urandom, $urandom});
            3: w = t_word'($signed($urandom_range(0, 32'h0FFFFFFF))) - (t_word'(1) <<< 27);
            default: w = t_word'(int'($urandom_range(0, 32'h07FFFFFF)) - 32'sh03FFFFFF);
        endcase
        return w;
    endfunction

    // Sends one item and waits for its acceptance; updates the predictor.
    // Valid stays high after acceptance so that items can follow back to back.
    task automatic send_item(logic mode, logic [7:0] idx, logic [3:0] sel,
                             t_word val, t_word ds, t_word dv);
        while (send_idle_pct > 0 && $urandom_range(1, 100) <= send_idle_pct) begin
            req_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_ch.valid        <= 1'b1;
        req_ch.mode         <= mode;
        req_ch.option_index <= idx;
        req_ch.word_select  <= sel;
        req_ch.load_value   <= val;
        req_ch.spot_shift   <= ds;
        req_ch.vol_shift    <= dv;
        do @(posedge i_clk); while (!req_ch.ready);
        if (mode == MODE_LOAD) begin
            loads_sent++;
            if (sel < WORDS) begin
                greek_table[idx][sel] = val;
                loaded[idx][sel] = 1'b1;
            end
        end else begin
            reprices_sent++;
            pending_prices.insert(pending_prices.size(), reprice(idx, ds, dv));
        end
    endtask

    task automatic load_row(logic [7:0] idx, bit extreme);
        for (int w = 0; w < WORDS; w++)
            send_item(MODE_LOAD, idx, 4'(w), extreme ? (w[0] ? WORD_MIN : WORD_MAX)
                      : rand_word(), t_word'($urandom), t_word'($urandom));
    endtask

    function automatic bit row_full(logic [7:0] idx);
        for (int w = 0; w < WORDS; w++) if (!loaded[idx][w]) return 1'b0;
        return 1'b1;
    endfunction

    task automatic drain();
        req_ch.valid <= 1'b0;
        while (pending_prices.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 2) @(posedge i_clk);
    endtask

    task automatic test_directed();
        load_row(8'd0, 1'b1);
        load_row(8'd255, 1'b0);
        // Out-of-range word select must leave the row untouched.
        send_item(MODE_LOAD, 8'd0, 4'd15, 48'h123456789ABC, '0, '0);
        send_item(MODE_LOAD, 8'd0, 4'd11, WORD_MIN, '0, '0);
        send_item(MODE_REPRICE, 8'd0, 4'd0, '0, '0, '0);
        send_item(MODE_REPRICE, 8'd0, 4'd15, WORD_MAX, WORD_MAX, WORD_MAX);
        send_item(MODE_REPRICE, 8'd0, 4'd0, '0, WORD_MIN, WORD_MIN);
        send_item(MODE_REPRICE, 8'd255, 4'd0, '0, WORD_MAX, WORD_MIN);
        send_item(MODE_REPRICE, 8'd255, 4'd0, '0, 48'sd16777216, -48'sd8388608);
        // Reload then reprice back to back: the new word must be seen.
        send_item(MODE_LOAD, 8'd255, W_GAMMA, WORD_MAX, '0, '0);
        send_item(MODE_REPRICE, 8'd255, 4'd0, '0, -48'sd1, 48'sd1);
        drain();
    endtask

    task automatic test_random(int count, int idle_pct, int stall_pct);
        logic [7:0] idx;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        for (int n = 0; n < count; n++) begin
            idx = 8'($urandom_range(0, 15));
            if (!row_full(idx) || $urandom_range(0, 99) < 25) begin
                send_item(MODE_LOAD, idx, 4'($urandom_range(0, 15)), rand_word(),
                          rand_word(), rand_word());
                if (!row_full(idx)) load_row(idx, 1'b0);
            end else begin
                send_item(MODE_REPRICE, idx, 4'($urandom), rand_word(),
                          rand_word(), rand_word());
            end
        end
        drain();
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rsp_ch.ready <= 1'b0;
        end else begin
            rsp_ch.ready <= !(recv_stall_pct > 0 && $urandom_range(1, 100) <= recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (i_rst_n && rsp_ch.valid && rsp_ch.ready) begin
            got = '{rsp_ch.entry_echo, rsp_ch.new_call_price, rsp_ch.new_put_price,
                    rsp_ch.new_call_delta, rsp_ch.new_put_delta, rsp_ch.new_vega,
                    rsp_ch.kept_gamma, rsp_ch.kept_theta, rsp_ch.kept_rho_call,
                    rsp_ch.kept_rho_put, rsp_ch.kept_vanna, rsp_ch.kept_vomma};
            results_seen++;
            if (pending_prices.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result for entry %0d", got.entry_echo);
            end else begin
                want = pending_prices.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch entry %0d\n  expected %h\n  actual   %h",
                                 want.entry_echo, want, got);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= MAX_QUIET) begin
            $display("** option_greeks_taylor_reprice_core: FAILED **");
            $finish;
        end
    end

    initial begin
        i_clk = 1'b0;
        quiet_cycles = 0;
        mismatches = 0;
        results_seen = 0;
        loads_sent = 0;
        reprices_sent = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        foreach (loaded[i, w]) loaded[i][w] = 1'b0;
        i_rst_n <= 1'b0;
        req_ch.valid <= 1'b0;
        req_ch.mode <= MODE_LOAD;
        req_ch.option_index <= '0;
        req_ch.word_select <= '0;
        req_ch.load_value <= '0;
        req_ch.spot_shift <= '0;
        req_ch.vol_shift <= '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random(200, 0, 0);
        test_random(180, 59, 0);
        test_random(180, 0, 59);
        test_random(180, 21, 21);
        $display("Sent %0d loads and %0d reprices; %0d results checked.",
                 loads_sent, reprices_sent, results_seen);
        if (mismatches == 0 && pending_prices.size() == 0) begin
            $display("** option_greeks_taylor_reprice_core: PASSED **");
        end else begin
            $display("%0d mismatches, %0d results missing", mismatches,
                     pending_prices.size());
            $display("** option_greeks_taylor_reprice_core: FAILED **");
        end
        $finish;
    end

endmodule
